>>> sv/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants and types of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 40;
	localparam logic [31:0] HEAP_LIMIT_RST = 32'd1048576;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ZERO    = 2'd1,
		ST_NOSPACE = 2'd2,
		ST_BADFREE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_HOLD
	} fsm_t;

	// request token handed from cell to cell
	typedef struct packed {
		logic        tv;
		op_t         op;
		logic        done;
		logic        append;
		logic        fits;
		status_t     status;
		logic [31:0] size;
		logic [31:0] addr;
	} tok_t;

endpackage

>>> sv/ffba_cell.sv
// ----------------------------------------------------------------------------
// ffba_cell
// One block record; resolves a passing request against it and hands the
// token on to the next cell through a register.
// ----------------------------------------------------------------------------
module ffba_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  ffba_pkg::tok_t tin,
	output ffba_pkg::tok_t tout
);

	logic        live_q;
	logic        free_q;
	logic [31:0] start_q;
	logic [31:0] size_q;

	logic           open_req;
	logic           hit_alloc;
	logic           take_new;
	logic           hit_free;
	logic [32:0]    payload;
	ffba_pkg::tok_t tnext;

	assign payload   = {1'b0, start_q} + 33'(ffba_pkg::HEADER_BYTES);
	assign open_req  = tin.tv && !tin.done;
	assign hit_alloc = open_req && (tin.op == ffba_pkg::OP_ALLOC) && live_q && free_q
		&& (size_q >= tin.size);
	assign take_new  = open_req && (tin.op == ffba_pkg::OP_ALLOC) && !live_q && tin.fits;
	assign hit_free  = open_req && (tin.op == ffba_pkg::OP_FREE) && live_q
		&& (payload == {1'b0, tin.addr});

	always_comb begin
		tnext = tin;
		if (hit_alloc) begin
			tnext.done   = 1'b1;
			tnext.status = ffba_pkg::ST_OK;
			tnext.addr   = payload[31:0];
		end else if (take_new) begin
			tnext.done   = 1'b1;
			tnext.append = 1'b1;
			tnext.status = ffba_pkg::ST_OK;
			tnext.addr   = tin.addr + 32'(ffba_pkg::HEADER_BYTES);
		end else if (hit_free) begin
			tnext.done   = 1'b1;
			tnext.status = free_q ? ffba_pkg::ST_BADFREE : ffba_pkg::ST_OK;
			tnext.addr   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (hit_alloc) begin
				free_q <= 1'b0;
			end else if (take_new) begin
				live_q <= 1'b1;
				free_q <= 1'b0;
			end else if (hit_free) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_new) begin
			start_q <= tin.addr;
			size_q  <= tin.size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tout <= '0;
		end else begin
			tout <= tnext;
		end
	end

endmodule

>>> sv/ffba_chain.sv
// ----------------------------------------------------------------------------
// ffba_chain
// Row of block record cells in creation order; live records form a prefix.
// ----------------------------------------------------------------------------
module ffba_chain (
	input  logic           clk,
	input  logic           arst_n,
	input  ffba_pkg::tok_t tin,
	output ffba_pkg::tok_t tout
);

	ffba_pkg::tok_t tok [0:ffba_pkg::MAX_BLOCKS];

	assign tok[0] = tin;

	for (genvar i = 0; i < ffba_pkg::MAX_BLOCKS; i++) begin : g_cell
		ffba_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tin    (tok[i]),
			.tout   (tok[i+1])
		);
	end

	assign tout = tok[ffba_pkg::MAX_BLOCKS];

endmodule

>>> sv/first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit heap allocator over a chain of block record cells.
// ----------------------------------------------------------------------------
// Requests are served one at a time. A zero size allocate or a null free gives
// its result in the cycle after it is accepted. Every other request is sent as
// a token down the row of MAX_BLOCKS record cells, one cell per cycle, through
// an input register, the cells and a pending result register; the next item is
// taken once that result has moved to the output register and the output side
// can take it. Freed blocks are reused whole, new blocks are appended at the
// heap break, and heap_limit is written through the cfg port.
module first_fit_block_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [31:0] req_size,
	input  logic [31:0] free_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] alloc_addr,
	output logic [1:0]  status
);

	ffba_pkg::fsm_t state_q;
	ffba_pkg::fsm_t state_d;

	logic [31:0] heap_limit_q;
	logic [31:0] break_q;
	logic [31:0] nb_q;

	ffba_pkg::tok_t tok_d;
	ffba_pkg::tok_t tok_s0;
	ffba_pkg::tok_t chain_out;

	logic               out_valid_q;
	logic [31:0]        alloc_addr_q;
	ffba_pkg::status_t  status_q;
	logic [31:0]        pend_addr_q;
	ffba_pkg::status_t  pend_status_q;

	logic        out_free;
	logic        acc;
	logic        quick;
	logic [33:0] new_break;
	logic        fits;
	logic        load_quick;
	logic        load_pend;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == ffba_pkg::FSM_IDLE) && out_free);
	assign acc       = in_valid && !in_stall;
	assign quick     = (op == ffba_pkg::OP_ALLOC) ? (req_size == '0) : (free_addr == '0);
	assign new_break = {2'b0, break_q} + 34'(ffba_pkg::HEADER_BYTES) + {2'b0, req_size};
	assign fits      = new_break <= {2'b0, heap_limit_q};

	always_comb begin
		tok_d = '0;
		if (acc && !quick) begin
			tok_d.tv   = 1'b1;
			tok_d.op   = ffba_pkg::op_t'(op);
			tok_d.fits = fits;
			tok_d.size = req_size;
			tok_d.addr = (op == ffba_pkg::OP_ALLOC) ? break_q : free_addr;
		end
	end

	always_comb begin
		state_d    = state_q;
		load_quick = 1'b0;
		load_pend  = 1'b0;
		case (state_q)
			ffba_pkg::FSM_IDLE: begin
				if (acc) begin
					if (quick) begin
						load_quick = 1'b1;
					end else begin
						state_d = ffba_pkg::FSM_SCAN;
					end
				end
			end
			ffba_pkg::FSM_SCAN: begin
				if (chain_out.tv) begin
					state_d = ffba_pkg::FSM_HOLD;
				end
			end
			ffba_pkg::FSM_HOLD: begin
				if (out_free) begin
					load_pend = 1'b1;
					state_d   = ffba_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = ffba_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= ffba_pkg::HEAP_LIMIT_RST;
			break_q      <= '0;
			tok_s0       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				heap_limit_q <= cfg_data;
			end
			tok_s0 <= tok_d;
			if (state_q == ffba_pkg::FSM_SCAN && chain_out.tv && chain_out.append) begin
				break_q <= nb_q;
			end
			if (load_quick || load_pend) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			nb_q <= new_break[31:0];
		end
		if (state_q == ffba_pkg::FSM_SCAN && chain_out.tv) begin
			if (chain_out.done) begin
				pend_addr_q   <= chain_out.addr;
				pend_status_q <= chain_out.status;
			end else begin
				pend_addr_q   <= '0;
				pend_status_q <= (chain_out.op == ffba_pkg::OP_ALLOC) ?
					ffba_pkg::ST_NOSPACE : ffba_pkg::ST_BADFREE;
			end
		end
		if (load_quick) begin
			alloc_addr_q <= '0;
			status_q     <= (op == ffba_pkg::OP_ALLOC) ? ffba_pkg::ST_ZERO : ffba_pkg::ST_OK;
		end else if (load_pend) begin
			alloc_addr_q <= pend_addr_q;
			status_q     <= pend_status_q;
		end
	end

	ffba_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.tin    (tok_s0),
		.tout   (chain_out)
	);

	assign out_valid  = out_valid_q;
	assign alloc_addr = alloc_addr_q;
	assign status     = status_q;

	// an accepted item is either answered at once or starts a scan
	a_acc_progress: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (out_valid_q || state_q == ffba_pkg::FSM_SCAN))
		else $error("accepted item neither answered nor scanning");

	// the chain only returns a token while a scan is open
	a_chain_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain_out.tv |-> state_q == ffba_pkg::FSM_SCAN)
		else $error("token left the chain outside a scan");

	// an appended block always resolves an allocate
	a_append_done: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_out.tv && chain_out.append) |->
			(chain_out.done && chain_out.op == ffba_pkg::OP_ALLOC))
		else $error("append without resolved allocate");

	// results with a status other than ST_OK never carry an address
	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ffba_pkg::ST_OK) |-> alloc_addr_q == '0)
		else $error("address on a failed item");

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit block allocator core. A local model
// of the record table predicts every result. Directed requests cover the
// corner cases, then random allocate and free traffic runs under several
// heap limits while both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [31:0]       addr;
		ffba_pkg::status_t st;
	} grant_t;

	logic          clk;
	logic          arst_n;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [31:0]   cfg_data;
	logic          in_valid;
	logic          in_stall;
	ffba_pkg::op_t op;
	logic [31:0]   req_size;
	logic [31:0]   free_addr;
	logic          out_valid;
	logic          out_stall;
	logic [31:0]   alloc_addr;
	logic [1:0]    status;

	// local copy of the allocator state
	logic [31:0] rec_start [ffba_pkg::MAX_BLOCKS];
	logic [31:0] rec_size [ffba_pkg::MAX_BLOCKS];
	bit          rec_free [ffba_pkg::MAX_BLOCKS];
	int          rec_count = 0;
	logic [31:0] brk = '0;
	logic [31:0] limit_now = ffba_pkg::HEAP_LIMIT_RST;

	grant_t grants_due [$];
	grant_t head_grant;
	bit     no_idle = 1'b0;
	int     n_err = 0;
	int     n_limit_writes = 0;
	int     seen_status [4] = '{default: 0};
	int     cycle_count = 0;

	first_fit_block_allocator_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.req_size   (req_size),
		.free_addr  (free_addr),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.alloc_addr (alloc_addr),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic grant_t heap_step(input ffba_pkg::op_t kind, input logic [31:0] size,
		input logic [31:0] addr);
		grant_t      g;
		logic [32:0] end_pos;
		int          i;
		g.addr = '0;
		g.st = ffba_pkg::ST_OK;
		if (kind == ffba_pkg::OP_ALLOC) begin
			if (size == 0) begin
				g.st = ffba_pkg::ST_ZERO;
				return g;
			end
			for (i = 0; i < rec_count; i++) begin
				if (rec_free[i] && rec_size[i] >= size) begin
					rec_free[i] = 1'b0;
					g.addr = rec_start[i] + 32'(ffba_pkg::HEADER_BYTES);
					return g;
				end
			end
			end_pos = {1'b0, brk} + 33'(ffba_pkg::HEADER_BYTES) + {1'b0, size};
			if (rec_count >= ffba_pkg::MAX_BLOCKS || end_pos > {1'b0, limit_now}) begin
				g.st = ffba_pkg::ST_NOSPACE;
				return g;
			end
			rec_start[rec_count] = brk;
			rec_size[rec_count] = size;
			rec_free[rec_count] = 1'b0;
			rec_count++;
			g.addr = brk + 32'(ffba_pkg::HEADER_BYTES);
			brk = end_pos[31:0];
			return g;
		end
		if (addr == 0)
			return g;
		for (i = 0; i < rec_count; i++) begin
			if ({1'b0, rec_start[i]} + 33'(ffba_pkg::HEADER_BYTES) == {1'b0, addr}) begin
				if (rec_free[i])
					g.st = ffba_pkg::ST_BADFREE;
				else
					rec_free[i] = 1'b1;
				return g;
			end
		end
		g.st = ffba_pkg::ST_BADFREE;
		return g;
	endfunction

	function automatic logic [31:0] pick_size(input int unsigned small_max);
		int unsigned r;
		int unsigned k;
		r = $urandom_range(99);
		if (r < 4)
			return '0;
		if (r < 9)
			return $urandom;
		if (r < 14)
			return $urandom_range(200000, 10000);
		if (r < 55 && rec_count != 0) begin
			k = $urandom_range(rec_count - 1);
			return rec_size[k] + $urandom_range(2) - 1;
		end
		return $urandom_range(small_max, 1);
	endfunction

	function automatic logic [31:0] pick_free_addr();
		int unsigned r;
		int unsigned k;
		r = $urandom_range(99);
		if (rec_count == 0 || r < 8)
			return $urandom;
		if (r < 12)
			return '0;
		k = $urandom_range(rec_count - 1);
		// near miss on a real payload offset
		if (r < 18)
			return rec_start[k] + 32'(ffba_pkg::HEADER_BYTES)
				+ ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
		// prefer a block in use so that most frees succeed
		if (rec_free[k])
			k = $urandom_range(rec_count - 1);
		return rec_start[k] + 32'(ffba_pkg::HEADER_BYTES);
	endfunction

	task automatic send_item(input ffba_pkg::op_t kind, input logic [31:0] size,
		input logic [31:0] addr);
		if (!no_idle && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		req_size <= size;
		free_addr <= addr;
		do @(posedge clk); while (in_stall);
		grants_due.push_back(heap_step(kind, size, addr));
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (grants_due.size() != 0) @(posedge clk);
		repeat (ffba_pkg::MAX_BLOCKS + 8) @(posedge clk);
	endtask

	task automatic write_limit(input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_now = value;
		n_limit_writes++;
	endtask

	task automatic churn_item();
		if ($urandom_range(99) < 50)
			send_item(ffba_pkg::OP_ALLOC, pick_size(3000), $urandom);
		else
			send_item(ffba_pkg::OP_FREE, $urandom, pick_free_addr());
	endtask

	task automatic test_basic_requests();
		send_item(ffba_pkg::OP_ALLOC, 32'd0, 32'd0);
		send_item(ffba_pkg::OP_FREE, 32'hFFFF_FFFF, 32'd0);
		send_item(ffba_pkg::OP_FREE, 32'd0, 32'd40);
		send_item(ffba_pkg::OP_ALLOC, 32'd1, 32'd0);
		send_item(ffba_pkg::OP_ALLOC, 32'd100, 32'hFFFF_FFFF);
		send_item(ffba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
		send_item(ffba_pkg::OP_ALLOC, 32'hFFFF_FFFF - 32'd100, 32'd0);
		send_item(ffba_pkg::OP_FREE, 32'd0, 32'd40);
		send_item(ffba_pkg::OP_FREE, 32'd0, 32'd40);
		send_item(ffba_pkg::OP_FREE, 32'd0, 32'd41);
		send_item(ffba_pkg::OP_ALLOC, 32'd2, 32'd0);
		send_item(ffba_pkg::OP_ALLOC, 32'd1, 32'd0);
		send_item(ffba_pkg::OP_FREE, 32'd0, 32'd81);
		send_item(ffba_pkg::OP_ALLOC, 32'd50, 32'd0);
		send_item(ffba_pkg::OP_FREE, 32'd0, 32'hFFFF_FFFF);
	endtask

	task automatic test_heap_limit_edges();
		wait_results_done();
		write_limit(32'd0);
		send_item(ffba_pkg::OP_ALLOC, 32'd1, 32'd0);
		send_item(ffba_pkg::OP_FREE, 32'd0, 32'd40);
		send_item(ffba_pkg::OP_ALLOC, 32'd1, 32'd0);
		wait_results_done();
		write_limit(brk + 32'(ffba_pkg::HEADER_BYTES) + 32'd7);
		send_item(ffba_pkg::OP_ALLOC, 32'd8, 32'd0);
		send_item(ffba_pkg::OP_ALLOC, 32'd7, 32'd0);
		wait_results_done();
		// one byte past the top of the address space
		write_limit(32'hFFFF_FFFF);
		send_item(ffba_pkg::OP_ALLOC,
			32'hFFFF_FFFF - brk - 32'(ffba_pkg::HEADER_BYTES) + 32'd1, 32'd0);
	endtask

	task automatic test_random_churn();
		int n;
		wait_results_done();
		write_limit(brk + $urandom_range(60000, 20000));
		for (n = 0; n < 450; n++) begin
			no_idle = (n >= 150 && n < 300);
			churn_item();
			if ($urandom_range(59) == 0)
				wait_results_done();
		end
		no_idle = 1'b0;
	endtask

	task automatic test_table_full();
		logic [31:0] biggest;
		int          i;
		wait_results_done();
		write_limit(ffba_pkg::HEAP_LIMIT_RST);
		while (rec_count < ffba_pkg::MAX_BLOCKS)
			send_item(ffba_pkg::OP_ALLOC, $urandom_range(256, 1), $urandom);
		biggest = '0;
		for (i = 0; i < rec_count; i++)
			if (rec_size[i] > biggest)
				biggest = rec_size[i];
		send_item(ffba_pkg::OP_ALLOC, biggest + 32'd1, 32'd0);
	endtask

	task automatic test_wide_limit();
		int n;
		wait_results_done();
		write_limit(32'hFFFF_FFFF);
		for (n = 0; n < 400; n++) begin
			churn_item();
			if ($urandom_range(79) == 0)
				wait_results_done();
		end
	endtask

	always @(posedge clk) begin
		out_stall <= !no_idle && ($urandom_range(99) < 34);
		if (out_valid === 1'b1 && !out_stall) begin
			if (grants_due.size() == 0) begin
				$display("%0t: result with nothing expected: addr %h status %0d",
					$time, alloc_addr, status);
				n_err++;
			end else begin
				head_grant = grants_due.pop_front();
				seen_status[head_grant.st]++;
				if (alloc_addr !== head_grant.addr) begin
					$display("%0t: alloc_addr expected %h actual %h",
						$time, head_grant.addr, alloc_addr);
					n_err++;
				end
				if (status !== head_grant.st) begin
					$display("%0t: status expected %0d actual %0d",
						$time, head_grant.st, status);
					n_err++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, grants_due.size());
			$display("** first_fit_block_allocator_core: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = ffba_pkg::OP_ALLOC;
		req_size = '0;
		free_addr = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_requests();
		test_heap_limit_edges();
		test_random_churn();
		test_table_full();
		test_wide_limit();
		wait_results_done();
		$display("checked results: %0d ok, %0d zero size, %0d out of space, %0d bad free",
			seen_status[ffba_pkg::ST_OK], seen_status[ffba_pkg::ST_ZERO],
			seen_status[ffba_pkg::ST_NOSPACE], seen_status[ffba_pkg::ST_BADFREE]);
		$display("heap limit written %0d times incl. zero and all ones, %0d records at end",
			n_limit_writes, rec_count);
		if (n_err == 0)
			$display("** first_fit_block_allocator_core: PASSED **");
		else
			$display("** first_fit_block_allocator_core: FAILED **");
		$finish;
	end

endmodule
